// ----- rtl/emp_pkg.sv -----
// Shared types, constants and codes for the energy meter pulse front end.
`default_nettype none
package emp_pkg;

  localparam int TIME_W      = 32;
  localparam int SCALE_W     = 32;
  localparam int OPC_W       = 2;
  localparam int RES_W       = 16;
  localparam int ENG_W       = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 88;

  // Energy is pulse count times power scale over this many microseconds.
  localparam logic [SCALE_W-1:0] ENERGY_DIVISOR = 32'd1000000;

  // Divider retires two quotient bits per cycle.
  localparam int DIV_BITS  = 32;
  localparam int DIV_STEPS = DIV_BITS / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};
  localparam logic [ENG_W-1:0] ENG_MAX = {ENG_W{1'b1}};

  typedef enum logic [OPC_W-1:0] {
    OP_POWER  = 2'd0,
    OP_SELECT = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_POWER_SCALE   = 3'd0,
    REG_VOLTAGE_SCALE = 3'd1,
    REG_CURRENT_SCALE = 3'd2,
    REG_SETTLE        = 3'd3,
    REG_CUR_LEVEL     = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_PWR = 2'd0,
    DIV_CUR = 2'd1,
    DIV_VOL = 2'd2,
    DIV_ENG = 2'd3
  } div_sel_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic     load;        // capture accepted request
    logic     event_op;    // apply power edge, select edge or clear
    logic     read_pre;    // power timeout and energy product
    logic     sel_step;    // current clear and select timeout
    logic     div_start;
    div_sel_t div_sel;
    logic     store_res;   // store divider result for div_sel
    logic     out_load;    // move result into output register
  } emp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    opcode_t op;
    logic    div_busy;
    logic    div_done;
    logic    out_stall;
  } emp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/emp_div.sv -----
// Iterative restoring divider, two quotient bits per cycle, 64/32 with high word below divisor.
`default_nettype none
module emp_div
  import emp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DIV_BITS-1:0] num_hi,
  input  wire logic [DIV_BITS-1:0] num_lo,
  input  wire logic [DIV_BITS-1:0] den,
  output      logic                busy,
  output      logic                done,
  output      logic [DIV_BITS-1:0] quot
);

  logic [DIV_BITS-1:0]  rem_r;
  logic [DIV_BITS-1:0]  num_r;
  logic [DIV_BITS-1:0]  den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;

  logic [DIV_BITS:0]    step1, step2;

  // One restoring step: shift in a bit, subtract when it fits.
  function automatic logic [DIV_BITS:0] div_step(input logic [DIV_BITS-1:0] rem,
                                                 input logic in_bit,
                                                 input logic [DIV_BITS-1:0] d);
    logic [DIV_BITS:0] t;
    logic [DIV_BITS:0] diff;
    t    = {rem, in_bit};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, diff[DIV_BITS-1:0]};
    end else begin
      div_step = {1'b0, t[DIV_BITS-1:0]};
    end
  endfunction

  assign step1 = div_step(rem_r, num_r[DIV_BITS-1], den_r);
  assign step2 = div_step(step1[DIV_BITS-1:0], num_r[DIV_BITS-2], den_r);

  // Count down the iterations.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == DIV_CNT_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  // Shift numerator out and quotient in through the same register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num_hi;
      num_r <= num_lo;
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= step2[DIV_BITS-1:0];
      num_r <= {num_r[DIV_BITS-3:0], step1[DIV_BITS], step2[DIV_BITS]};
    end
  end

  assign busy = (cnt_r != '0);
  assign done = done_r;
  assign quot = num_r;

endmodule
`default_nettype wire

// ----- rtl/emp_dp.sv -----
// Datapath: configuration, measurement state, energy product, divider and result register.
`default_nettype none
module emp_dp
  import emp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [SCALE_W-1:0]     cfg_wdata,
  input  wire logic [OPC_W-1:0]       in_opcode,
  input  wire logic [TIME_W-1:0]      in_now,
  input  wire logic                   out_tready,
  input  wire emp_cmd_t               cmd,
  output      emp_stat_t              stat,
  output      logic                   out_tvalid,
  output      logic [OUT_TDATA_W-1:0] out_tdata
);

  // Configuration registers
  logic [SCALE_W-1:0] power_scale_r, voltage_scale_r, current_scale_r, settle_r;
  logic               cur_level_r;

  // Measurement state
  logic [TIME_W-1:0]  last_power_edge_r, last_select_edge_r, window_start_r;
  logic [TIME_W-1:0]  power_period_r, current_period_r, voltage_period_r;
  logic [ENG_W-1:0]   pulse_total_r;
  logic               select_level_r;

  // Request and results
  opcode_t            op_r;
  logic [TIME_W-1:0]  now_r;
  logic [2*SCALE_W-1:0] prod_r;
  logic [RES_W-1:0]   pw_r, vv_r, ic_r;
  logic [ENG_W-1:0]   en_r;
  logic               out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [TIME_W-1:0]  since_power, since_select, since_window;
  logic               selected_is_cur;
  logic [DIV_BITS-1:0] div_hi, div_lo, div_den, div_q;
  logic               div_busy, div_done;
  logic               den_zero;
  logic [RES_W-1:0]   q16;

  assign since_power     = now_r - last_power_edge_r;
  assign since_select    = now_r - last_select_edge_r;
  assign since_window    = now_r - window_start_r;
  assign selected_is_cur = (select_level_r == cur_level_r);

  // Write configuration; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_scale_r   <= '0;
      voltage_scale_r <= '0;
      current_scale_r <= '0;
      settle_r        <= 32'd2000000;
      cur_level_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_POWER_SCALE:   power_scale_r   <= cfg_wdata;
        REG_VOLTAGE_SCALE: voltage_scale_r <= cfg_wdata;
        REG_CURRENT_SCALE: current_scale_r <= cfg_wdata;
        REG_SETTLE:        settle_r        <= cfg_wdata;
        REG_CUR_LEVEL:     cur_level_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Capture the accepted request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode_t'(in_opcode);
      now_r <= in_now;
    end
  end

  // Update measurement state per command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_power_edge_r  <= '0;
      last_select_edge_r <= '0;
      window_start_r     <= '0;
      power_period_r     <= '0;
      current_period_r   <= '0;
      voltage_period_r   <= '0;
      pulse_total_r      <= '0;
      select_level_r     <= 1'b1;
    end else if (cmd.event_op) begin
      case (op_r)
        OP_POWER: begin
          power_period_r    <= since_power;
          last_power_edge_r <= now_r;
          pulse_total_r     <= pulse_total_r + ENG_W'(1);
        end
        OP_SELECT: begin
          // Close the settle window: store the gated period and flip select.
          if (since_window > settle_r) begin
            if (selected_is_cur) begin
              current_period_r <= (last_select_edge_r == window_start_r) ? '0 : since_select;
            end else begin
              voltage_period_r <= (last_select_edge_r == window_start_r) ? '0 : since_select;
            end
            select_level_r <= ~select_level_r;
            window_start_r <= now_r;
          end
          last_select_edge_r <= now_r;
        end
        OP_CLEAR: begin
          pulse_total_r <= '0;
        end
        default: ;
      endcase
    end else if (cmd.read_pre) begin
      if (since_power > settle_r) begin
        power_period_r <= '0;
      end
    end else if (cmd.sel_step) begin
      if (pw_r == '0) begin
        current_period_r <= '0;
      end
      // Stale select line: drop the selected period and flip select.
      if (since_select > settle_r) begin
        if (selected_is_cur) begin
          current_period_r <= '0;
        end else begin
          voltage_period_r <= '0;
        end
        select_level_r     <= ~select_level_r;
        last_select_edge_r <= now_r;
        window_start_r     <= now_r;
      end
    end
  end

  // Form the energy product; pulse count is steady during a read.
  always_ff @(posedge clk) begin
    if (cmd.read_pre) begin
      prod_r <= pulse_total_r * power_scale_r;
    end
  end

  // Select divider operands.
  always_comb begin
    div_hi = '0;
    case (cmd.div_sel)
      DIV_PWR: begin div_lo = power_scale_r;   div_den = power_period_r;   end
      DIV_CUR: begin div_lo = current_scale_r; div_den = current_period_r; end
      DIV_VOL: begin div_lo = voltage_scale_r; div_den = voltage_period_r; end
      DIV_ENG: begin
        div_hi  = prod_r[2*SCALE_W-1:SCALE_W];
        div_lo  = prod_r[SCALE_W-1:0];
        div_den = ENERGY_DIVISOR;
      end
      default: begin div_lo = '0; div_den = '0; end
    endcase
  end

  emp_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .num_hi (div_hi),
    .num_lo (div_lo),
    .den    (div_den),
    .busy   (div_busy),
    .done   (div_done),
    .quot   (div_q)
  );

  // Saturate to the result width; a zero period reads as zero.
  assign den_zero = (div_den == '0);
  assign q16 = den_zero ? '0 :
               (div_q > DIV_BITS'(RES_MAX)) ? RES_MAX : div_q[RES_W-1:0];

  // Store results; a new request starts from zeros.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pw_r <= '0;
      vv_r <= '0;
      ic_r <= '0;
      en_r <= '0;
    end else if (cmd.store_res) begin
      case (cmd.div_sel)
        DIV_PWR: pw_r <= q16;
        DIV_CUR: ic_r <= q16;
        DIV_VOL: vv_r <= q16;
        DIV_ENG: en_r <= (prod_r[2*SCALE_W-1:SCALE_W] >= ENERGY_DIVISOR) ? ENG_MAX
                                                                           : div_q;
        default: ;
      endcase
    end
  end

  // Hold the result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load | (out_valid_r & ~out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {6'd0, en_r, ic_r, vv_r, pw_r, selected_is_cur, select_level_r};
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_data_r;
  assign stat.op        = op_r;
  assign stat.div_busy  = div_busy;
  assign stat.div_done  = div_done;
  assign stat.out_stall = out_valid_r & ~out_tready;

endmodule
`default_nettype wire

// ----- rtl/emp_ctrl.sv -----
// Controller: sequences event updates and the four divisions of a read.
`default_nettype none
module emp_ctrl
  import emp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output      logic      in_tready,
  input  wire emp_stat_t stat,
  output      emp_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_EXEC  = 12'b0000_0000_0010,
    S_DIVP  = 12'b0000_0000_0100,
    S_WAITP = 12'b0000_0000_1000,
    S_SELT  = 12'b0000_0001_0000,
    S_DIVI  = 12'b0000_0010_0000,
    S_WAITI = 12'b0000_0100_0000,
    S_DIVV  = 12'b0000_1000_0000,
    S_WAITV = 12'b0001_0000_0000,
    S_DIVE  = 12'b0010_0000_0000,
    S_WAITE = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance through the read sequence; other requests take one step.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = DIV_PWR;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_tvalid;
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.op == OP_READ) begin
          cmd.read_pre = 1'b1;
          state_nxt    = S_DIVP;
        end else begin
          cmd.event_op = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DIVP: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAITP;
      end
      S_WAITP: begin
        cmd.store_res = stat.div_done;
        if (stat.div_done) state_nxt = S_SELT;
      end
      S_SELT: begin
        cmd.sel_step = 1'b1;
        state_nxt    = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_sel   = DIV_CUR;
        cmd.div_start = 1'b1;
        state_nxt     = S_WAITI;
      end
      S_WAITI: begin
        cmd.div_sel   = DIV_CUR;
        cmd.store_res = stat.div_done;
        if (stat.div_done) state_nxt = S_DIVV;
      end
      S_DIVV: begin
        cmd.div_sel   = DIV_VOL;
        cmd.div_start = 1'b1;
        state_nxt     = S_WAITV;
      end
      S_WAITV: begin
        cmd.div_sel   = DIV_VOL;
        cmd.store_res = stat.div_done;
        if (stat.div_done) state_nxt = S_DIVE;
      end
      S_DIVE: begin
        cmd.div_sel   = DIV_ENG;
        cmd.div_start = 1'b1;
        state_nxt     = S_WAITE;
      end
      S_WAITE: begin
        cmd.div_sel   = DIV_ENG;
        cmd.store_res = stat.div_done;
        if (stat.div_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.out_load = ~stat.out_stall;
        if (!stat.out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/energy_meter_pulse_front_end_top.sv -----
// Top level of the energy meter pulse front end: controller, datapath and checks.
`default_nettype none
// One request at a time. A power edge, select-line edge or energy clear is applied in
// the execute step, then enters the output register from the done state, which returns
// to idle once the output is free. A read reaches the output register after four passes
// of the shared divider for power, current, voltage and energy (each a start step, 16
// iterations of two quotient bits and a done step) plus one setup, one select timeout
// and one output step. A finished result waits in the output register while the next
// request is accepted; the request after that stalls until the result is taken.
// Configuration writes (cfg_addr 0 power scale, 1 voltage scale, 2 current scale,
// 3 settle timeout, 4 current select level) take effect at once.
module energy_meter_pulse_front_end_top
  import emp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [SCALE_W-1:0]     cfg_wdata,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] now_us
  input  wire logic [OPC_W-1:0]       in_tuser,   // [1:0] opcode
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  // [0] select_out, [1] current_selected, [17:2] power_w, [33:18] voltage_v,
  // [49:34] current_centiamp, [81:50] energy_ws, [87:82] zero
  output      logic [OUT_TDATA_W-1:0] out_tdata
);

  emp_cmd_t  cmd;
  emp_stat_t stat;

  emp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  emp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_opcode  (in_tuser),
    .in_now     (in_tdata[TIME_W-1:0]),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  // Leave idle after an accepted request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted but controller stayed idle");

  // Never restart the divider mid-division.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  // Never overwrite a result still waiting downstream.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result register overwritten before it was taken");

endmodule
`default_nettype wire

// ----- tb/energy_meter_pulse_front_end_top_test.sv -----
// Self-checking testbench for the energy meter pulse front end: directed and random requests.
`default_nettype none
module energy_meter_pulse_front_end_top_test;
  import emp_pkg::*;

  localparam int CLK_PERIOD       = 8;
  localparam int TIMEOUT_CYCLES   = 2000000;
  localparam int DRAIN_CYCLES     = 80;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam longint unsigned US_PER_S = 1000000;
  // Index past the register file; a write there must change nothing.
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic        sel;
    logic        cur_sel;
    logic [15:0] power;
    logic [15:0] volt;
    logic [15:0] cur;
    logic [31:0] energy;
  } meter_reading_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [SCALE_W-1:0]     cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [31:0] now_us
  logic [OPC_W-1:0]       in_tuser   = '0;   // [1:0] opcode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [0] select_out, [1] current_selected, [17:2] power_w, [33:18] voltage_v,
  // [49:34] current_centiamp, [81:50] energy_ws, [87:82] zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Pacing controls shared by the stimulus and the sink
  logic src_idle_en   = 1'b1;
  logic sink_stall_en = 1'b1;
  logic hold_sink     = 1'b0;

  int             mismatch_count = 0;
  int             result_count   = 0;
  meter_reading_t pending_readings[$];
  logic [31:0]    clock_us = '0;

  // Predicted meter state and register copies
  logic [31:0] m_k_power, m_k_volt, m_k_cur, m_settle;
  logic        m_cur_level;
  logic [31:0] m_pwr_edge, m_sel_edge, m_win_start;
  logic [31:0] m_pwr_period, m_cur_period, m_vol_period;
  logic [31:0] m_pulses;
  logic        m_sel_level;

  energy_meter_pulse_front_end_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin : clock_gen
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("energy_meter_pulse_front_end_top test failed");
    $finish;
  end

  // Truncating quotient clipped to 16 bits; a zero period reads as zero
  function automatic logic [15:0] sat_quot16(logic [31:0] num, logic [31:0] den);
    logic [31:0] q;
    if (den == 0) return '0;
    q = num / den;
    return (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  // Store a period for whichever quantity the select line chooses now
  function automatic void store_window_period(logic [31:0] p);
    if (m_sel_level == m_cur_level) m_cur_period = p;
    else m_vol_period = p;
  endfunction

  function automatic meter_reading_t predict_reading(opcode_t op, logic [31:0] stamp);
    meter_reading_t r;
    logic [31:0]    gap;
    logic [63:0]    prod;
    r = '{sel: 1'b0, cur_sel: 1'b0, power: '0, volt: '0, cur: '0, energy: '0};
    case (op)
      OP_POWER: begin
        m_pwr_period = stamp - m_pwr_edge;
        m_pwr_edge   = stamp;
        m_pulses     = m_pulses + 32'd1;
      end
      OP_SELECT: begin
        gap = stamp - m_win_start;
        if (gap > m_settle) begin
          // first edge of a window carries no period
          store_window_period((m_sel_edge == m_win_start) ? 32'd0 : stamp - m_sel_edge);
          m_sel_level = ~m_sel_level;
          m_win_start = stamp;
        end
        m_sel_edge = stamp;
      end
      OP_READ: begin
        gap = stamp - m_pwr_edge;
        if (gap > m_settle) m_pwr_period = '0;
        r.power = sat_quot16(m_k_power, m_pwr_period);
        if (r.power == 0) m_cur_period = '0;
        gap = stamp - m_sel_edge;
        if (gap > m_settle) begin
          store_window_period('0);
          m_sel_level = ~m_sel_level;
          m_sel_edge  = stamp;
          m_win_start = stamp;
        end
        r.cur  = sat_quot16(m_k_cur, m_cur_period);
        r.volt = sat_quot16(m_k_volt, m_vol_period);
        prod = {32'd0, m_pulses} * {32'd0, m_k_power};
        prod = prod / US_PER_S;
        r.energy = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
      end
      OP_CLEAR: m_pulses = '0;
      default: ;
    endcase
    r.sel     = m_sel_level;
    r.cur_sel = (m_sel_level == m_cur_level);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             result_count, what, got, want);
    mismatch_count++;
  endtask

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin : check_readings
    meter_reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], '0);
      end else begin
        want = pending_readings.pop_front();
        if (out_tdata[0] !== want.sel)
          report_mismatch("select_out", 32'(out_tdata[0]), 32'(want.sel));
        if (out_tdata[1] !== want.cur_sel)
          report_mismatch("current_selected", 32'(out_tdata[1]), 32'(want.cur_sel));
        if (out_tdata[17:2] !== want.power)
          report_mismatch("power_w", 32'(out_tdata[17:2]), 32'(want.power));
        if (out_tdata[33:18] !== want.volt)
          report_mismatch("voltage_v", 32'(out_tdata[33:18]), 32'(want.volt));
        if (out_tdata[49:34] !== want.cur)
          report_mismatch("current_centiamp", 32'(out_tdata[49:34]), 32'(want.cur));
        if (out_tdata[81:50] !== want.energy)
          report_mismatch("energy_ws", out_tdata[81:50], want.energy);
        if (out_tdata[87:82] !== 6'd0)
          report_mismatch("padding", 32'(out_tdata[87:82]), '0);
      end
      result_count++;
    end
  end

  // Pace the result side: random stall bursts, or one long hold on request
  initial begin : sink_pacing
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
        out_tready <= 1'b1;
      end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one request, wait for acceptance, then predict its reading
  task automatic send_request(input opcode_t op, input logic [31:0] stamp);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= stamp;
    do @(posedge clk); while (!in_tready);
    pending_readings.push_back(predict_reading(op, stamp));
  endtask

  // Drop valid and wait until every predicted reading has come back
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; call only while the block is idle
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_POWER_SCALE:   m_k_power   = value;
      REG_VOLTAGE_SCALE: m_k_volt    = value;
      REG_CURRENT_SCALE: m_k_cur     = value;
      REG_SETTLE:        m_settle    = value;
      REG_CUR_LEVEL:     m_cur_level = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Default registers: every quotient is zero, a huge wrapped power period
  task automatic test_reset_state();
    send_request(OP_READ, 32'd0);
    send_request(OP_POWER, 32'hFFFF_FFFF);
    send_request(OP_READ, 32'hFFFF_FFFF);
    quiesce();
  endtask

  // Hand-built edge sequence: window gating, stale periods, saturation, clear
  task automatic test_measurements();
    write_reg(REG_SETTLE, 32'd1000);
    write_reg(REG_POWER_SCALE, 32'd500000);
    write_reg(REG_VOLTAGE_SCALE, 32'd2300000);
    write_reg(REG_CURRENT_SCALE, 32'd150000);
    write_reg(REG_CUR_LEVEL, 32'd1);
    send_request(OP_POWER, 32'd10000);
    send_request(OP_POWER, 32'd10100);
    // first edge of a window stores zero, then a full window stores a period
    send_request(OP_SELECT, 32'd10110);
    send_request(OP_SELECT, 32'd10300);
    send_request(OP_SELECT, 32'd11200);
    // stale power period forces current to zero
    send_request(OP_READ, 32'd11250);
    send_request(OP_POWER, 32'd11300);
    send_request(OP_SELECT, 32'd11400);
    send_request(OP_SELECT, 32'd12300);
    send_request(OP_POWER, 32'd12000);
    send_request(OP_READ, 32'd12350);
    // select timeout on read clears and toggles
    send_request(OP_READ, 32'd15000);
    send_request(OP_POWER, 32'd15001);
    send_request(OP_POWER, 32'd15002);
    send_request(OP_READ, 32'd15003);
    send_request(OP_CLEAR, 32'd15004);
    send_request(OP_READ, 32'd15005);
    quiesce();
  endtask

  // Register extremes, an ignored index, select level rewrite, backwards time
  task automatic test_config_extremes();
    write_reg(REG_SETTLE, 32'hFFFF_FFFF);
    write_reg(REG_POWER_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_VOLTAGE_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_CURRENT_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED, $urandom);
    send_request(OP_POWER, 32'h8000_0000);
    send_request(OP_READ, 32'h7FFF_FFFF);
    quiesce();
    write_reg(REG_CUR_LEVEL, 32'd0);
    send_request(OP_READ, 32'h8000_0001);
    quiesce();
    write_reg(REG_SETTLE, 32'd1);
    send_request(OP_SELECT, 32'd2);
    send_request(OP_SELECT, 32'd3);
    send_request(OP_READ, 32'd5);
    quiesce();
    clock_us = 32'd5;
  endtask

  // Hold the result side for a long stretch while requests keep coming
  task automatic test_backpressure();
    hold_sink = 1'b1;
    repeat (12) begin
      clock_us = clock_us + $urandom_range(1, 3);
      send_request(opcode_t'($urandom_range(0, 3)), clock_us);
    end
    quiesce();
  endtask

  // One random phase: fresh registers, then a timestamp walk around the timeout
  task automatic run_random_phase(input logic [31:0] settle, input logic level,
                                  input int count);
    logic [31:0]     hi;
    logic [31:0]     delta;
    logic [63:0]     scale;
    int unsigned     pick;
    opcode_t         op;
    write_reg(REG_SETTLE, settle);
    write_reg(REG_CUR_LEVEL, {31'd0, level});
    for (int k = 0; k < 3; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) scale = 64'hFFFF_FFFF;
      else if (pick == 1) scale = '0;
      else if (pick == 2) scale = {32'd0, $urandom};
      else scale = {32'd0, settle} * $urandom_range(1, 4000) / 4;
      if (scale > 64'hFFFF_FFFF) scale = 64'hFFFF_FFFF;
      write_reg(cfg_reg_t'(k), scale[31:0]);
    end
    hi = (settle >= 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : 2 * settle + 1;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) op = OP_POWER;
      else if (pick < 60) op = OP_SELECT;
      else if (pick < 94) op = OP_READ;
      else op = OP_CLEAR;
      // mostly inside the window, some just past it, a few arbitrary jumps
      pick = $urandom_range(0, 99);
      if (pick < 5) delta = '0;
      else if (pick < 70) delta = $urandom_range(1, settle);
      else if (pick < 92) delta = $urandom_range(settle, hi);
      else delta = $urandom;
      clock_us = clock_us + delta;
      send_request(op, clock_us);
    end
    quiesce();
  endtask

  task automatic test_random();
    run_random_phase(32'd250, 1'b1, 270);
    run_random_phase(32'd1, 1'b0, 270);
    run_random_phase(32'd3000, 1'b0, 270);
    run_random_phase(32'hFFFF_FFFF, 1'b1, 270);
    run_random_phase(32'd60000, 1'b1, 270);
    // last stretch runs at full rate on both sides
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    run_random_phase(32'd1500, 1'b0, 270);
  endtask

  initial begin : stimulus
    m_k_power    = '0;
    m_k_volt     = '0;
    m_k_cur      = '0;
    m_settle     = 32'd2000000;
    m_cur_level  = 1'b1;
    m_pwr_edge   = '0;
    m_sel_edge   = '0;
    m_win_start  = '0;
    m_pwr_period = '0;
    m_cur_period = '0;
    m_vol_period = '0;
    m_pulses     = '0;
    m_sel_level  = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_measurements();
    test_config_extremes();
    test_backpressure();
    test_random();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("energy_meter_pulse_front_end_top test passed");
    end else begin
      $display("energy_meter_pulse_front_end_top test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
